// ----- hdl/cfb_pkg.sv -----
// ----------------------------------------------------------------------------
// cfb_pkg: shared types and constants of the command frame builder
// Holds the job record passed from the front part to the back part and the
// one-hot step codes of the byte sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package cfb_pkg;

    // Byte that opens every frame; it is not part of the checksum.
    localparam logic [7:0] FRAME_START = 8'hAA;

    // One classified request, ready to be turned into bytes.
    typedef struct packed {
        logic        is_header;  // frame header, else payload word
        logic        rnw;        // read header (no count bytes)
        logic        close;      // checksum byte follows the last data byte
        logic [15:0] reg_addr;   // register number of a header
        logic [15:0] data;       // word count of a write header, or payload word
    } job_t;

    // Byte sequencer steps, one-hot.
    typedef enum logic [7:0] {
        STEP_IDLE    = 8'b0000_0001,
        STEP_START   = 8'b0000_0010,
        STEP_ADDR    = 8'b0000_0100,
        STEP_REG_HI  = 8'b0000_1000,
        STEP_REG_LO  = 8'b0001_0000,
        STEP_DATA_HI = 8'b0010_0000,
        STEP_DATA_LO = 8'b0100_0000,
        STEP_SUM     = 8'b1000_0000
    } step_t;

endpackage

`default_nettype wire

// ----- hdl/cfb_front.sv -----
// ----------------------------------------------------------------------------
// cfb_front: request classifier
// Tracks whether a write frame is open and how many payload words it still
// expects, and turns each accepted request into a job or drops it.
// ----------------------------------------------------------------------------
`default_nettype none

module cfb_front
    import cfb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic        command,
    input  wire logic        read_not_write,
    input  wire logic [15:0] register_address,
    input  wire logic [15:0] word_count,
    input  wire logic [15:0] payload_word,
    output logic             push,
    output job_t             push_job
);

    logic        frame_open_reg;
    logic        frame_open_next;
    logic [15:0] words_left_reg;
    logic [15:0] words_left_next;
    logic        count_zero;
    logic        last_word;

    assign count_zero = (word_count == 16'd0);
    assign last_word  = (words_left_reg == 16'd1);

    // Classify the request and update the frame tracking.
    always_comb
    begin
        frame_open_next    = frame_open_reg;
        words_left_next    = words_left_reg;
        push               = 1'b0;
        push_job.is_header = ~command;
        push_job.rnw       = read_not_write;
        push_job.reg_addr  = register_address;
        push_job.data      = command ? payload_word : word_count;
        push_job.close     = command ? last_word : (read_not_write | count_zero);
        if (accept)
        begin
            if (!command)
            begin
                // A header always starts a new frame and abandons an open one.
                push = 1'b1;
                if (read_not_write || count_zero)
                begin
                    frame_open_next = 1'b0;
                    words_left_next = 16'd0;
                end
                else
                begin
                    frame_open_next = 1'b1;
                    words_left_next = word_count;
                end
            end
            else if (frame_open_reg)
            begin
                // A payload word counts down the open frame.
                push            = 1'b1;
                words_left_next = words_left_reg - 16'd1;
                if (last_word)
                begin
                    frame_open_next = 1'b0;
                end
            end
        end
    end

    // Frame tracking registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_open_reg <= 1'b0;
            words_left_reg <= 16'd0;
        end
        else
        begin
            frame_open_reg <= frame_open_next;
            words_left_reg <= words_left_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/cfb_queue.sv -----
// ----------------------------------------------------------------------------
// cfb_queue: job queue
// A short first-in first-out queue of jobs between the classifier and the
// byte sequencer, so that either side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module cfb_queue
    import cfb_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire job_t push_job,
    input  wire logic pop,
    output job_t      head,
    output logic      head_valid,
    output logic      full
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] PTR_STEP = PTR_W'(1);
    localparam logic [CNT_W-1:0] CNT_STEP = CNT_W'(1);

    job_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == FULL_CNT);
    assign head       = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_STEP;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_STEP;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_STEP;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_STEP;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Job storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/cfb_back.sv -----
// ----------------------------------------------------------------------------
// cfb_back: byte sequencer
// Turns queued jobs into frame bytes, one per cycle unless the output stalls,
// keeps the running checksum and drives the registered output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module cfb_back
    import cfb_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic [6:0] device_address,
    input  wire job_t       head,
    input  wire logic       head_valid,
    output logic            pop,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      tx_byte,
    output logic            frame_end
);

    step_t      state_reg;
    step_t      state_next;
    step_t      cur_step;
    step_t      after_step;
    job_t       job_reg;
    job_t       cur_job;
    logic [7:0] sum_reg;
    logic [7:0] sum_next;
    logic       out_valid_reg;
    logic [7:0] tx_byte_reg;
    logic       frame_end_reg;
    logic [7:0] cur_byte;
    logic       active;
    logic       have_byte;
    logic       advance;
    logic       emit;

    assign out_valid = out_valid_reg;
    assign tx_byte   = tx_byte_reg;
    assign frame_end = frame_end_reg;

    // The first byte of a new job comes straight from the queue head.
    always_comb
    begin
        active    = (state_reg != STEP_IDLE);
        cur_job   = active ? job_reg : head;
        if (active)
        begin
            cur_step = state_reg;
        end
        else
        begin
            cur_step = head.is_header ? STEP_START : STEP_DATA_HI;
        end
        have_byte = active || head_valid;
        advance   = !out_valid_reg || out_ready;
        emit      = have_byte && advance;
        pop       = emit && !active;
    end

    // Byte of the current step and the step after it.
    always_comb
    begin
        case (cur_step)
            STEP_START:
            begin
                cur_byte   = FRAME_START;
                after_step = STEP_ADDR;
            end
            STEP_ADDR:
            begin
                cur_byte   = {cur_job.rnw, device_address};
                after_step = STEP_REG_HI;
            end
            STEP_REG_HI:
            begin
                cur_byte   = cur_job.reg_addr[15:8];
                after_step = STEP_REG_LO;
            end
            STEP_REG_LO:
            begin
                cur_byte   = cur_job.reg_addr[7:0];
                after_step = cur_job.rnw ? STEP_SUM : STEP_DATA_HI;
            end
            STEP_DATA_HI:
            begin
                cur_byte   = cur_job.data[15:8];
                after_step = STEP_DATA_LO;
            end
            STEP_DATA_LO:
            begin
                cur_byte   = cur_job.data[7:0];
                after_step = cur_job.close ? STEP_SUM : STEP_IDLE;
            end
            STEP_SUM:
            begin
                cur_byte   = sum_reg;
                after_step = STEP_IDLE;
            end
            default:
            begin
                cur_byte   = 8'd0;
                after_step = STEP_IDLE;
            end
        endcase
    end

    // Checksum covers every byte after the start byte, up to the sum itself.
    always_comb
    begin
        sum_next   = sum_reg;
        state_next = state_reg;
        if (emit)
        begin
            state_next = after_step;
            if (cur_step == STEP_START || cur_step == STEP_SUM)
            begin
                sum_next = 8'd0;
            end
            else
            begin
                sum_next = sum_reg + cur_byte;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= STEP_IDLE;
            sum_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sum_reg   <= sum_next;
            if (advance)
            begin
                out_valid_reg <= have_byte;
            end
        end
    end

    // Payload registers: current job and output byte.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            job_reg       <= cur_job;
            tx_byte_reg   <= cur_byte;
            frame_end_reg <= (cur_step == STEP_SUM);
        end
    end

endmodule

`default_nettype wire

// ----- hdl/command_frame_builder_core.sv -----
// ----------------------------------------------------------------------------
// command_frame_builder_core: serial command frame builder
// Builds sensor command frames as a byte stream closed by an 8-bit sum.
// ----------------------------------------------------------------------------
//  Channel   Signals                                   Direction  Moves
//  input     in_valid/in_ready + request fields        in         one request
//  output    out_valid/out_ready + tx_byte, frame_end  out        one frame byte
//  config    cfg_write_enable + cfg_write_data         in         device address
//
//  One byte leaves per cycle through the output register unless out_ready
//  stalls it; a read header gives 5 bytes, a write header 6 or 7, a payload
//  word 2 or 3; a payload word outside a frame is dropped by the classifier.
//  Requests are accepted while the job queue has room, also while bytes of
//  earlier requests are still going out. Reset clears all control state at
//  once; there is no clearing pass. A stalled output holds its byte.
// ----------------------------------------------------------------------------
`default_nettype none

module command_frame_builder_core
    import cfb_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_write_enable,
    input  wire logic [6:0]  cfg_write_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        command,
    input  wire logic        read_not_write,
    input  wire logic [15:0] register_address,
    input  wire logic [15:0] word_count,
    input  wire logic [15:0] payload_word,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       tx_byte,
    output logic             frame_end
);

    logic [6:0] device_address_reg;
    logic       queue_full;
    logic       accept;
    logic       push;
    job_t       push_job;
    job_t       head;
    logic       head_valid;
    logic       pop;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    // Device address register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            device_address_reg <= 7'd0;
        end
        else if (cfg_write_enable)
        begin
            device_address_reg <= cfg_write_data;
        end
    end

    // Front part: request classification and frame tracking.
    cfb_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .accept           (accept),
        .command          (command),
        .read_not_write   (read_not_write),
        .register_address (register_address),
        .word_count       (word_count),
        .payload_word     (payload_word),
        .push             (push),
        .push_job         (push_job)
    );

    // Job queue between the two parts.
    cfb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .full       (queue_full)
    );

    // Back part: byte sequencing and checksum.
    cfb_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .device_address (device_address_reg),
        .head           (head),
        .head_valid     (head_valid),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .tx_byte        (tx_byte),
        .frame_end      (frame_end)
    );

endmodule

`default_nettype wire

// ----- hdl/cfb_checker.sv -----
// ----------------------------------------------------------------------------
// cfb_checker: port-level checks of the frame builder
// Watches the top-level ports over time and reports violations.
// ----------------------------------------------------------------------------
`default_nettype none

module cfb_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       command,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] tx_byte,
    input wire logic       frame_end
);

    // A stalled output byte stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(tx_byte) && $stable(frame_end))
        else $error("output byte changed while stalled");

    // Nothing is offered right after reset is released.
    a_reset_quiet: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("output valid right after reset");

    // An accepted header request must be followed by an offered output byte.
    a_header_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !command |-> ##2 out_valid)
        else $error("header request produced no output byte");

endmodule

bind command_frame_builder_core cfb_checker u_cfb_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .tx_byte   (tx_byte),
    .frame_end (frame_end)
);

`default_nettype wire

// ----- test/tb_frame_check_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frame_check_pkg: frame prediction and byte checking for the builder bench
// Holds a scoreboard class that predicts the byte stream of each accepted
// request and compares every byte that leaves the block with the oldest one
// still expected.
// ----------------------------------------------------------------------------

package tb_frame_check_pkg;

    import cfb_pkg::FRAME_START;

    // Request kinds and the direction bit of a header.
    localparam logic CMD_HEADER = 1'b0;
    localparam logic CMD_WORD   = 1'b1;
    localparam logic RNW_WRITE  = 1'b0;
    localparam logic RNW_READ   = 1'b1;

    // Only the first few mismatches are printed in full.
    localparam int SHOWN_MISMATCHES = 10;

    class frame_scoreboard;

        typedef struct packed {
            logic [7:0] tx;
            logic       last;
        } frame_byte_t;

        frame_byte_t expected_bytes[$];
        logic [6:0]  device_addr;
        logic [7:0]  running_sum;
        logic [15:0] words_left;
        logic        frame_open;
        int          failures;

        function new();
            device_addr = 7'd0;
            running_sum = 8'd0;
            words_left  = 16'd0;
            frame_open  = 1'b0;
            failures    = 0;
        endfunction

        function void set_device_address(logic [6:0] value);
            device_addr = value;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        // Queue one byte, adding it to the checksum when it is covered.
        function void push_byte(logic [7:0] value, logic summed, logic last);
            frame_byte_t entry;
            entry.tx   = value;
            entry.last = last;
            expected_bytes = {expected_bytes, entry};
            if (summed)
                running_sum = running_sum + value;
        endfunction

        // The checksum byte ends the frame and clears the frame state.
        function void close_frame();
            push_byte(running_sum, 1'b0, 1'b1);
            running_sum = 8'd0;
            words_left  = 16'd0;
            frame_open  = 1'b0;
        endfunction

        // Predict the bytes of one accepted request; returns how many it adds.
        function int note_request(logic cmd, logic rnw, logic [15:0] reg_addr,
                                  logic [15:0] count, logic [15:0] word);
            int queued;
            queued = expected_bytes.size();
            if (cmd == CMD_HEADER)
            begin
                // A header always starts over, abandoning any open frame.
                running_sum = 8'd0;
                words_left  = 16'd0;
                frame_open  = 1'b0;
                push_byte(FRAME_START, 1'b0, 1'b0);
                push_byte({rnw, device_addr}, 1'b1, 1'b0);
                push_byte(reg_addr[15:8], 1'b1, 1'b0);
                push_byte(reg_addr[7:0], 1'b1, 1'b0);
                if (rnw == RNW_READ)
                    close_frame();
                else
                begin
                    push_byte(count[15:8], 1'b1, 1'b0);
                    push_byte(count[7:0], 1'b1, 1'b0);
                    if (count == 16'd0)
                        close_frame();
                    else
                    begin
                        words_left = count;
                        frame_open = 1'b1;
                    end
                end
            end
            else if (frame_open)
            begin
                // Payload words only count inside an open write frame.
                push_byte(word[15:8], 1'b1, 1'b0);
                push_byte(word[7:0], 1'b1, 1'b0);
                words_left = words_left - 16'd1;
                if (words_left == 16'd0)
                    close_frame();
            end
            return expected_bytes.size() - queued;
        endfunction

        // Compare one delivered byte with the oldest expectation.
        function void check_byte(logic [7:0] tx, logic last);
            frame_byte_t want;
            if (expected_bytes.size() == 0)
            begin
                failures++;
                if (failures <= SHOWN_MISMATCHES)
                    $display("mismatch: unexpected byte tx_byte=%02h frame_end=%0b", tx, last);
                return;
            end
            want = expected_bytes.pop_front();
            if (tx !== want.tx || last !== want.last)
            begin
                failures++;
                if (failures <= SHOWN_MISMATCHES)
                    $display("mismatch: expected tx_byte=%02h frame_end=%0b, got %02h %0b",
                             want.tx, want.last, tx, last);
            end
        endfunction

    endclass

endpackage

// ----- test/tb_command_frame_builder_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_command_frame_builder_core: self-checking bench for the frame builder
// Drives directed and random header and payload requests under several
// device addresses, with random gaps on the request side and random stalls
// on the byte side, and checks every frame byte against a prediction.
// ----------------------------------------------------------------------------

module tb_command_frame_builder_core;

    import tb_frame_check_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 20;
    localparam int RANDOM_PHASES = 4;
    localparam int PHASE_ITEMS   = 30;

    logic        clk              = 1'b0;
    logic        rst_n            = 1'b0;
    logic        cfg_write_enable = 1'b0;
    logic [6:0]  cfg_write_data   = 7'd0;
    logic        in_valid         = 1'b0;
    logic        in_ready;
    logic        command          = CMD_HEADER;
    logic        read_not_write   = RNW_WRITE;
    logic [15:0] register_address = 16'd0;
    logic [15:0] word_count       = 16'd0;
    logic [15:0] payload_word     = 16'd0;
    logic        out_valid;
    logic        out_ready        = 1'b0;
    logic [7:0]  tx_byte;
    logic        frame_end;

    frame_scoreboard frame_model;
    logic            quiet_mode = 1'b0;
    int              busy_requests = 0;
    int              cycle_count = 0;

    command_frame_builder_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_write_enable (cfg_write_enable),
        .cfg_write_data   (cfg_write_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .command          (command),
        .read_not_write   (read_not_write),
        .register_address (register_address),
        .word_count       (word_count),
        .payload_word     (payload_word),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .tx_byte          (tx_byte),
        .frame_end        (frame_end)
    );

    // Clock with a 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The byte side stalls at random except in the quiet phase.
    always @(negedge clk)
        out_ready <= quiet_mode || ($urandom_range(0, 99) >= 35);

    // Every delivered byte is checked against the prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            frame_model.check_byte(tx_byte, frame_end);
    end

    // Guard against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[command_frame_builder_core] ERROR");
            $finish;
        end
    end

    // Present one request, wait until it is taken, and record its bytes.
    // Called and returning at a falling edge; valid stays up on return.
    task automatic send_request(logic cmd, logic rnw, logic [15:0] reg_addr,
                                logic [15:0] count, logic [15:0] word);
        while (!quiet_mode && $urandom_range(0, 99) < 35)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid         <= 1'b1;
        command          <= cmd;
        read_not_write   <= rnw;
        register_address <= reg_addr;
        word_count       <= count;
        payload_word     <= word;
        do
            @(posedge clk);
        while (!in_ready);
        if (frame_model.note_request(cmd, rnw, reg_addr, count, word) > 0)
            busy_requests++;
        @(negedge clk);
    endtask

    // Header request; the payload field carries junk.
    task automatic send_header(logic rnw, logic [15:0] reg_addr, logic [15:0] count);
        send_request(CMD_HEADER, rnw, reg_addr, count, 16'($urandom));
    endtask

    // Payload word request; the header fields carry junk.
    task automatic send_word(logic [15:0] word);
        send_request(CMD_WORD, 1'($urandom), 16'($urandom), 16'($urandom), word);
    endtask

    // Let the block go idle, then write the device address.
    task automatic write_device_address(logic [6:0] value);
        in_valid <= 1'b0;
        while (frame_model.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_write_enable <= 1'b1;
        cfg_write_data   <= value;
        @(negedge clk);
        cfg_write_enable <= 1'b0;
        frame_model.set_device_address(value);
    endtask

    // Random frames: mostly complete ones, some abandoned, some stray words.
    task automatic run_random_frames(int target);
        logic        rnw;
        logic [15:0] count;
        int          words;
        int          pick;
        while (busy_requests < target)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                send_word(16'($urandom));
            else
            begin
                rnw  = ($urandom_range(0, 3) == 0) ? RNW_READ : RNW_WRITE;
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    count = 16'd0;
                else if (pick < 20)
                    count = 16'($urandom_range(0, 65535));
                else
                    count = 16'($urandom_range(1, 4));
                send_header(rnw, 16'($urandom), count);
                if (rnw == RNW_WRITE && count != 16'd0)
                begin
                    words = (count <= 16'd4) ? int'(count) : $urandom_range(1, 3);
                    // Now and then leave the frame short so the next header drops it.
                    if ($urandom_range(0, 9) == 0)
                        words = $urandom_range(0, words - 1);
                    repeat (words) send_word(16'($urandom));
                end
            end
        end
    endtask

    initial
    begin
        frame_model = new();

        // Reset held, then released at a falling edge.
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed requests with the widest device address.
        write_device_address(7'h7F);
        send_word(16'hFFFF);                          // stray word after reset
        send_header(RNW_READ, 16'hFFFF, 16'hFFFF);
        send_header(RNW_READ, 16'h0000, 16'h0000);
        send_header(RNW_WRITE, 16'h1234, 16'h0000);   // write with no words
        send_header(RNW_WRITE, 16'hA5C3, 16'h0001);
        send_word(16'hFFFF);
        send_word(16'h0000);                          // stray word after a frame
        send_header(RNW_WRITE, 16'h00FF, 16'h0002);
        send_word(16'h0000);
        send_word(16'h8001);
        send_header(RNW_WRITE, 16'hFF00, 16'hFFFF);
        send_word(16'h5A5A);
        send_header(RNW_READ, 16'h7E81, 16'h0000);    // drops the open frame
        send_header(RNW_WRITE, 16'h0F0F, 16'h0003);
        send_word(16'hF0F0);
        send_header(RNW_WRITE, 16'h3C3C, 16'h0001);   // drops a write frame
        send_word(16'h1357);

        // Directed requests with the device address at zero.
        write_device_address(7'h00);
        send_header(RNW_READ, 16'h8000, 16'h0000);
        send_header(RNW_WRITE, 16'h0001, 16'h8000);
        send_word(16'hFFFF);
        send_header(RNW_WRITE, 16'hC0DE, 16'h0002);
        send_word(16'h0F0F);
        send_word(16'hF0F0);

        // Random phases, each under a new address; the second one never idles.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            write_device_address(7'($urandom_range(0, 127)));
            quiet_mode    = (phase == 1);
            busy_requests = 0;
            run_random_frames(PHASE_ITEMS);
        end
        quiet_mode = 1'b0;

        // Wait for the last bytes, then a short drain.
        in_valid <= 1'b0;
        while (frame_model.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (frame_model.failures == 0)
            $display("[command_frame_builder_core] OK");
        else
            $display("[command_frame_builder_core] ERROR");
        $finish;
    end

endmodule
